FILE: rtl/core/abmw_pkg.sv
// shared types, constants and helper functions for the maze walk block
package abmw_pkg;

  // grid limits
  localparam int MAX_CELL_ROWS = 32;
  localparam int MAX_CELL_COLS = 32;

  // field and state widths
  localparam int REG_W   = 7;   // config register width
  localparam int POS_W   = 6;   // maze coordinate width
  localparam int CELL_W  = 5;   // cell coordinate width (maze coordinate / 2)
  localparam int GRID_W  = 6;   // cells along one axis, 1..32
  localparam int LEFT_W  = 11;  // unvisited cell count
  localparam int EPOCH_W = 4;   // visited mark tag
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  // register reset value and clamp limit
  localparam logic [REG_W-1:0] REG_RESET = 7'd63;
  localparam logic [REG_W-1:0] REG_LIMIT = 7'd64;

  // request codes
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  // direction codes
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  // register index (paddr bit 2)
  localparam logic REG_IDX_ROWS = 1'b0;
  localparam logic REG_IDX_COLS = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [1:0] direction;
  } abmw_in_t;

  typedef struct packed {
    logic             moved;
    logic             carved;
    logic [POS_W-1:0] wall_row;
    logic [POS_W-1:0] wall_col;
    logic [POS_W-1:0] pos_row;
    logic [POS_W-1:0] pos_col;
    logic             finished;
  } abmw_out_t;

  // control from the handshake stage to the walker core
  typedef struct packed {
    logic       item_v;
    logic       fire;
    abmw_in_t   item;
    logic [1:0] occ_dir;
  } abmw_ctrl_t;

  // status from the walker core
  typedef struct packed {
    logic sweeping;
    logic hold;
  } abmw_stat_t;

  // neighbor cell of a move
  typedef struct packed {
    logic              ok;
    logic [CELL_W-1:0] nr;
    logic [CELL_W-1:0] nc;
  } abmw_tgt_t;

  // cells along one axis from a register value
  function automatic logic [GRID_W-1:0] cells_along(input logic [REG_W-1:0] reg_val,
                                                     input int cap);
    logic [REG_W-1:0]  n;
    logic [GRID_W-1:0] c;
    n = reg_val;
    if (n == '0) n = REG_W'(1);
    if (n > REG_LIMIT) n = REG_LIMIT;
    c = GRID_W'((n + REG_W'(1)) >> 1);
    if (int'(c) > cap) c = GRID_W'(cap);
    return c;
  endfunction

  // neighbor cell in a direction, ok when it stays inside the grid
  function automatic abmw_tgt_t step_target(input logic [CELL_W-1:0] cr,
                                            input logic [CELL_W-1:0] cc,
                                            input logic [1:0]        dir,
                                            input logic [GRID_W-1:0] gr,
                                            input logic [GRID_W-1:0] gc);
    abmw_tgt_t t;
    t.ok = 1'b0;
    t.nr = cr;
    t.nc = cc;
    case (dir)
      DIR_UP: begin
        t.ok = (cr != '0);
        t.nr = cr - CELL_W'(1);
      end
      DIR_DOWN: begin
        t.ok = ((GRID_W'(cr) + GRID_W'(1)) < gr);
        t.nr = cr + CELL_W'(1);
      end
      DIR_LEFT: begin
        t.ok = (cc != '0);
        t.nc = cc - CELL_W'(1);
      end
      DIR_RIGHT: begin
        t.ok = ((GRID_W'(cc) + GRID_W'(1)) < gc);
        t.nc = cc + CELL_W'(1);
      end
      default: begin
        t.ok = 1'b0;
      end
    endcase
    return t;
  endfunction

endpackage

FILE: rtl/core/abmw_ram.sv
// generic single write port ram with registered read
module abmw_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/abmw_cfg.sv
// apb register file holding the maze size registers
module abmw_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [abmw_pkg::APB_AW-1:0]  paddr,
  input  logic [abmw_pkg::APB_DW-1:0]  pwdata,
  output logic [abmw_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  output logic [abmw_pkg::REG_W-1:0]   maze_rows,
  output logic [abmw_pkg::REG_W-1:0]   maze_cols
);

  logic [abmw_pkg::REG_W-1:0] rows_r, rows_nxt;
  logic [abmw_pkg::REG_W-1:0] cols_r, cols_nxt;
  logic                       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  // register write decode
  always_comb begin
    rows_nxt = rows_r;
    cols_nxt = cols_r;
    if (wr_en) begin
      if (paddr[2] == abmw_pkg::REG_IDX_ROWS) begin
        rows_nxt = pwdata[abmw_pkg::REG_W-1:0];
      end else begin
        cols_nxt = pwdata[abmw_pkg::REG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= abmw_pkg::REG_RESET;
      cols_r <= abmw_pkg::REG_RESET;
    end else begin
      rows_r <= rows_nxt;
      cols_r <= cols_nxt;
    end
  end

  // read mux
  always_comb begin
    if (paddr[2] == abmw_pkg::REG_IDX_COLS) begin
      prdata = abmw_pkg::APB_DW'(cols_r);
    end else begin
      prdata = abmw_pkg::APB_DW'(rows_r);
    end
  end

  assign maze_rows = rows_r;
  assign maze_cols = cols_r;

endmodule

FILE: rtl/core/abmw_core.sv
// walker state, visited map with epoch tags and the per-word step logic
module abmw_core #(
  parameter int MAX_CELL_ROWS = abmw_pkg::MAX_CELL_ROWS,
  parameter int MAX_CELL_COLS = abmw_pkg::MAX_CELL_COLS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [abmw_pkg::REG_W-1:0] maze_rows,
  input  logic [abmw_pkg::REG_W-1:0] maze_cols,
  input  abmw_pkg::abmw_ctrl_t       ctrl,
  output abmw_pkg::abmw_stat_t       stat,
  output abmw_pkg::abmw_out_t        res
);

  localparam int DEPTH = MAX_CELL_ROWS * MAX_CELL_COLS;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [abmw_pkg::EPOCH_W-1:0] EPOCH_MAX = '1;

  localparam int CW = abmw_pkg::CELL_W;
  localparam int GW = abmw_pkg::GRID_W;
  localparam int LW = abmw_pkg::LEFT_W;
  localparam int PW = abmw_pkg::POS_W;
  localparam int EW = abmw_pkg::EPOCH_W;

  // walker and maze state
  logic [CW-1:0] cr_r, cr_nxt;
  logic [CW-1:0] cc_r, cc_nxt;
  logic [GW-1:0] grid_rows_r, grid_rows_nxt;
  logic [GW-1:0] grid_cols_r, grid_cols_nxt;
  logic [LW-1:0] left_r, left_nxt;
  logic          done_r, done_nxt;
  logic [EW-1:0] epoch_r, epoch_nxt;
  logic          sweep_r, sweep_nxt;
  logic [IDX_W-1:0] sweep_cnt_r, sweep_cnt_nxt;

  // map port signals
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [EW-1:0]    wr_data;
  logic [IDX_W-1:0] rd_addr;
  logic [EW-1:0]    rd_q;

  logic                    is_start;
  logic                    wrap_hold;
  logic                    visited;
  abmw_pkg::abmw_tgt_t     tgt;
  abmw_pkg::abmw_tgt_t     occ_tgt;
  logic [GW-1:0]           new_rows;
  logic [GW-1:0]           new_cols;
  logic [2*GW-1:0]         new_cells;

  function automatic logic [IDX_W-1:0] cell_index(input logic [CW-1:0] nr,
                                                  input logic [CW-1:0] nc);
    return IDX_W'(int'(nr) * MAX_CELL_COLS + int'(nc));
  endfunction

  abmw_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_q)
  );

  assign is_start  = (ctrl.item.req_type == abmw_pkg::REQ_START);
  assign wrap_hold = ctrl.item_v & is_start & (epoch_r == EPOCH_MAX);
  assign stat.sweeping = sweep_r;
  assign stat.hold     = sweep_r | wrap_hold;

  // a cell is visited when its tag matches the current epoch
  assign visited = (rd_q == epoch_r);
  assign tgt     = abmw_pkg::step_target(cr_r, cc_r, ctrl.item.direction,
                                         grid_rows_r, grid_cols_r);

  // grid size for a start word
  assign new_rows  = abmw_pkg::cells_along(maze_rows, MAX_CELL_ROWS);
  assign new_cols  = abmw_pkg::cells_along(maze_cols, MAX_CELL_COLS);
  assign new_cells = new_rows * new_cols;

  // clearing pass, step and start update
  always_comb begin
    cr_nxt        = cr_r;
    cc_nxt        = cc_r;
    grid_rows_nxt = grid_rows_r;
    grid_cols_nxt = grid_cols_r;
    left_nxt      = left_r;
    done_nxt      = done_r;
    epoch_nxt     = epoch_r;
    sweep_nxt     = sweep_r;
    sweep_cnt_nxt = sweep_cnt_r;
    wr_en         = 1'b0;
    wr_addr       = sweep_cnt_r;
    wr_data       = '0;
    res.moved     = 1'b0;
    res.carved    = 1'b0;
    res.wall_row  = '0;
    res.wall_col  = '0;

    if (sweep_r) begin
      // clearing pass, one entry a cycle
      wr_en         = 1'b1;
      sweep_cnt_nxt = sweep_cnt_r + IDX_W'(1);
      if (sweep_cnt_r == LAST_IDX) begin
        sweep_nxt = 1'b0;
        epoch_nxt = '0;
      end
    end else if (wrap_hold) begin
      // epoch about to wrap: wipe stale tags first
      sweep_nxt     = 1'b1;
      sweep_cnt_nxt = '0;
    end else if (ctrl.fire) begin
      if (is_start) begin
        grid_rows_nxt = new_rows;
        grid_cols_nxt = new_cols;
        cr_nxt        = '0;
        cc_nxt        = '0;
        epoch_nxt     = epoch_r + EW'(1);
        wr_en         = 1'b1;
        wr_addr       = '0;
        wr_data       = epoch_r + EW'(1);
        left_nxt      = LW'(new_cells - (2*GW)'(1));
        done_nxt      = (LW'(new_cells - (2*GW)'(1)) == '0);
      end else if (!done_r && tgt.ok) begin
        res.moved = 1'b1;
        cr_nxt    = tgt.nr;
        cc_nxt    = tgt.nc;
        if (!visited) begin
          res.carved   = 1'b1;
          res.wall_row = PW'(cr_r) + PW'(tgt.nr);
          res.wall_col = PW'(cc_r) + PW'(tgt.nc);
          wr_en        = 1'b1;
          wr_addr      = cell_index(tgt.nr, tgt.nc);
          wr_data      = epoch_r;
          if (left_r != '0) begin
            left_nxt = left_r - LW'(1);
          end
          if (left_r <= LW'(1)) begin
            done_nxt = 1'b1;
          end
        end
      end
    end

    res.pos_row  = {cr_nxt, 1'b0};
    res.pos_col  = {cc_nxt, 1'b0};
    res.finished = done_nxt;
  end

  // prefetch the tag for the word that sits in the item register next cycle
  assign occ_tgt = abmw_pkg::step_target(cr_nxt, cc_nxt, ctrl.occ_dir,
                                         grid_rows_nxt, grid_cols_nxt);
  assign rd_addr = occ_tgt.ok ? cell_index(occ_tgt.nr, occ_tgt.nc) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cr_r        <= '0;
      cc_r        <= '0;
      grid_rows_r <= GW'(1);
      grid_cols_r <= GW'(1);
      left_r      <= '0;
      done_r      <= 1'b1;
      epoch_r     <= '0;
      sweep_r     <= 1'b1;
      sweep_cnt_r <= '0;
    end else begin
      cr_r        <= cr_nxt;
      cc_r        <= cc_nxt;
      grid_rows_r <= grid_rows_nxt;
      grid_cols_r <= grid_cols_nxt;
      left_r      <= left_nxt;
      done_r      <= done_nxt;
      epoch_r     <= epoch_nxt;
      sweep_r     <= sweep_nxt;
      sweep_cnt_r <= sweep_cnt_nxt;
    end
  end

endmodule

FILE: rtl/core/aldous_broder_maze_walk.sv
// Random-walk maze carver: a start word resets the walk on a grid of cells
// sized from maze_rows and maze_cols, and each step word moves the walker one
// cell in a given direction, carving the wall on a first visit. One result
// word comes out per input word. A word enters the item register and its
// result is registered as it completes, so one word per cycle is sustained
// while out_ready holds and no clearing pass runs; the limit is the single
// read-modify-write of the visited map per step, whose tag for the next word
// is prefetched from the ram while the current word completes. The visited
// map is a ram of MAX_CELL_ROWS*MAX_CELL_COLS epoch tags: after reset a
// clearing pass of all tags runs before any word is taken, and the same pass
// runs once every 15 start words as the epoch tag wraps, stalling that start.
// Configuration writes are accepted at any time, pready is always high.
module aldous_broder_maze_walk #(
  parameter int MAX_CELL_ROWS = abmw_pkg::MAX_CELL_ROWS,
  parameter int MAX_CELL_COLS = abmw_pkg::MAX_CELL_COLS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  abmw_pkg::abmw_in_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output abmw_pkg::abmw_out_t         out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [abmw_pkg::APB_AW-1:0] paddr,
  input  logic [abmw_pkg::APB_DW-1:0] pwdata,
  output logic [abmw_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);

  logic [abmw_pkg::REG_W-1:0] maze_rows;
  logic [abmw_pkg::REG_W-1:0] maze_cols;

  abmw_pkg::abmw_in_t   item_r, item_nxt;
  logic                 item_v_r, item_v_nxt;
  abmw_pkg::abmw_out_t  out_r, out_nxt;
  logic                 out_v_r, out_v_nxt;

  abmw_pkg::abmw_ctrl_t ctrl;
  abmw_pkg::abmw_stat_t stat;
  abmw_pkg::abmw_out_t  res;

  logic fire;
  logic in_acc;

  abmw_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .maze_rows (maze_rows),
    .maze_cols (maze_cols)
  );

  abmw_core #(
    .MAX_CELL_ROWS (MAX_CELL_ROWS),
    .MAX_CELL_COLS (MAX_CELL_COLS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .maze_rows (maze_rows),
    .maze_cols (maze_cols),
    .ctrl      (ctrl),
    .stat      (stat),
    .res       (res)
  );

  // handshake: item word completes when the result slot frees, unless held
  assign fire     = item_v_r & (~out_v_r | out_ready) & ~stat.hold;
  assign in_ready = ~stat.sweeping & (~item_v_r | fire);
  assign in_acc   = in_valid & in_ready;

  always_comb begin
    ctrl.item_v  = item_v_r;
    ctrl.fire    = fire;
    ctrl.item    = item_r;
    ctrl.occ_dir = (item_v_r && !fire) ? item_r.direction : in_data.direction;
  end

  // item and result register next values
  always_comb begin
    item_nxt   = in_acc ? in_data : item_r;
    item_v_nxt = in_acc ? 1'b1 : (fire ? 1'b0 : item_v_r);
    out_nxt    = fire ? res : out_r;
    out_v_nxt  = fire ? 1'b1 : (out_ready ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      item_v_r <= item_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // no word is taken during a clearing pass
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    stat.sweeping |-> !in_ready)
    else $error("input word accepted during clearing pass");

  // a completed word always shows up as a result next cycle
  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid)
    else $error("completed word produced no result");

  // a wall is only carved by a move
  a_carve_needs_move: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.carved |-> out_data.moved)
    else $error("carve reported without a move");

  // a held word never completes
  a_hold_blocks_fire: assert property (@(posedge clk) disable iff (!rst_n)
    stat.hold |-> !fire)
    else $error("word completed while held");
`endif

endmodule

FILE: dv/tb_aldous_broder_maze_walk.sv
// testbench for the random-walk maze carver: directed and random walks checked against a predictor
module tb_aldous_broder_maze_walk;

  localparam int WATCHDOG_CYCLES = 400000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int HOLD_CYCLES     = 300;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  abmw_pkg::abmw_in_t            in_data;
  logic                          out_valid;
  logic                          out_ready;
  abmw_pkg::abmw_out_t           out_data;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [abmw_pkg::APB_AW-1:0]   paddr;
  logic [abmw_pkg::APB_DW-1:0]   pwdata;
  logic [abmw_pkg::APB_DW-1:0]   prdata;
  logic                          pready;

  // walker model state
  bit                            visited [abmw_pkg::MAX_CELL_ROWS][abmw_pkg::MAX_CELL_COLS];
  logic [abmw_pkg::REG_W-1:0]    rows_reg = abmw_pkg::REG_RESET;
  logic [abmw_pkg::REG_W-1:0]    cols_reg = abmw_pkg::REG_RESET;
  int                            grid_h = 1;
  int                            grid_w = 1;
  logic [abmw_pkg::POS_W-1:0]    walk_row = '0;
  logic [abmw_pkg::POS_W-1:0]    walk_col = '0;
  int                            unvisited = 0;
  bit                            walk_done = 1'b1;
  abmw_pkg::abmw_out_t           walk_reports_q [$];

  // sender and receiver control
  int                            fail_count = 0;
  int                            burst_left = 0;
  bit                            no_gaps = 1'b0;
  bit                            long_hold_req = 1'b0;

  aldous_broder_maze_walk u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit
  initial begin
    #(2 * WATCHDOG_CYCLES);
    $display("TEST FAILED");
    $finish;
  end

  // grid cells along one axis for a register value
  function automatic int cells_on_axis(input logic [abmw_pkg::REG_W-1:0] v, input int cap);
    int n;
    n = int'(v);
    if (n < 1) n = 1;
    if (n > int'(abmw_pkg::REG_LIMIT)) n = int'(abmw_pkg::REG_LIMIT);
    n = (n + 1) / 2;
    if (n > cap) n = cap;
    return n;
  endfunction

  // apply one accepted word to the walker model and queue its report
  task automatic advance_walker(input abmw_pkg::abmw_in_t w);
    abmw_pkg::abmw_out_t r;
    int        cr;
    int        cc;
    int        nr;
    int        nc;
    bit        ok;
    r = '0;
    if (w.req_type == abmw_pkg::REQ_START) begin
      grid_h = cells_on_axis(rows_reg, abmw_pkg::MAX_CELL_ROWS);
      grid_w = cells_on_axis(cols_reg, abmw_pkg::MAX_CELL_COLS);
      for (int i = 0; i < abmw_pkg::MAX_CELL_ROWS; i++)
        for (int j = 0; j < abmw_pkg::MAX_CELL_COLS; j++)
          visited[i][j] = 1'b0;
      visited[0][0] = 1'b1;
      walk_row = '0;
      walk_col = '0;
      unvisited = grid_h * grid_w - 1;
      walk_done = (unvisited == 0);
    end else if (!walk_done) begin
      cr = int'(walk_row) / 2;
      cc = int'(walk_col) / 2;
      nr = cr;
      nc = cc;
      ok = 1'b0;
      case (w.direction)
        abmw_pkg::DIR_UP: begin
          if (cr > 0) begin nr = cr - 1; ok = 1'b1; end
        end
        abmw_pkg::DIR_DOWN: begin
          if (cr + 1 < grid_h) begin nr = cr + 1; ok = 1'b1; end
        end
        abmw_pkg::DIR_LEFT: begin
          if (cc > 0) begin nc = cc - 1; ok = 1'b1; end
        end
        abmw_pkg::DIR_RIGHT: begin
          if (cc + 1 < grid_w) begin nc = cc + 1; ok = 1'b1; end
        end
        default: ok = 1'b0;
      endcase
      if (ok) begin
        r.moved = 1'b1;
        // first visit carves the wall halfway between the two cells
        if (!visited[nr][nc]) begin
          visited[nr][nc] = 1'b1;
          r.carved = 1'b1;
          r.wall_row = abmw_pkg::POS_W'((int'(walk_row) + 2 * nr) / 2);
          r.wall_col = abmw_pkg::POS_W'((int'(walk_col) + 2 * nc) / 2);
          if (unvisited > 0) unvisited--;
          if (unvisited == 0) walk_done = 1'b1;
        end
        walk_row = abmw_pkg::POS_W'(2 * nr);
        walk_col = abmw_pkg::POS_W'(2 * nc);
      end
    end
    r.pos_row = walk_row;
    r.pos_col = walk_col;
    r.finished = walk_done;
    walk_reports_q.push_back(r);
  endtask

  // offer one word, wait for acceptance, then maybe leave a gap
  task automatic send_word(input logic req, input logic [1:0] dir);
    abmw_pkg::abmw_in_t w;
    w.req_type = req;
    w.direction = dir;
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_walker(w);
    if (!no_gaps) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (walk_reports_q.size() != 0) @(posedge clk);
  endtask

  // block idle: nothing offered, nothing outstanding, pipeline flushed
  task automatic settle_idle();
    stop_sending();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // setup and access cycle, random junk above the 7 register bits
  task automatic write_reg(input logic idx, input logic [abmw_pkg::REG_W-1:0] val);
    logic [abmw_pkg::APB_DW-1:0] data;
    data = $urandom;
    data[abmw_pkg::REG_W-1:0] = val;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    if (idx == abmw_pkg::REG_IDX_ROWS) rows_reg = val;
    else cols_reg = val;
  endtask

  function automatic logic [1:0] pick_dir(input logic [1:0] bias_dir, input int bias_pct);
    if ($urandom_range(0, 99) < bias_pct) return bias_dir;
    return 2'($urandom_range(0, 3));
  endfunction

  // mostly walk steps, some early restarts and sender pauses
  task automatic run_walks(input int n_items, input logic [1:0] bias_dir, input int bias_pct);
    int count;
    int r;
    count = 0;
    if ($urandom_range(0, 1) == 1) begin
      send_word(abmw_pkg::REQ_START, 2'($urandom_range(0, 3)));
      count++;
    end
    while (count < n_items) begin
      r = $urandom_range(0, 99);
      if (walk_done) begin
        if (r < 60) begin
          send_word(abmw_pkg::REQ_START, 2'($urandom_range(0, 3)));
          count++;
        end else begin
          send_word(abmw_pkg::REQ_STEP, 2'($urandom_range(0, 3)));
        end
      end else if (r < 3) begin
        send_word(abmw_pkg::REQ_START, 2'($urandom_range(0, 3)));
        count++;
      end else if (r < 5) begin
        stop_sending();
        wait_drained();
      end else begin
        send_word(abmw_pkg::REQ_STEP, pick_dir(bias_dir, bias_pct));
        count++;
      end
    end
  endtask

  task automatic run_phase(input logic [abmw_pkg::REG_W-1:0] rows,
                           input logic [abmw_pkg::REG_W-1:0] cols,
                           input int n_items, input logic [1:0] bias_dir, input int bias_pct);
    settle_idle();
    write_reg(abmw_pkg::REG_IDX_ROWS, rows);
    write_reg(abmw_pkg::REG_IDX_COLS, cols);
    run_walks(n_items, bias_dir, bias_pct);
  endtask

  // steps before any start are ignored
  task automatic test_idle_steps();
    send_word(abmw_pkg::REQ_STEP, abmw_pkg::DIR_UP);
    send_word(abmw_pkg::REQ_STEP, abmw_pkg::DIR_DOWN);
    send_word(abmw_pkg::REQ_STEP, abmw_pkg::DIR_LEFT);
    send_word(abmw_pkg::REQ_STEP, abmw_pkg::DIR_RIGHT);
  endtask

  // zero rows acts as one, two cols gives one cell: finished at start
  task automatic test_single_cell();
    settle_idle();
    write_reg(abmw_pkg::REG_IDX_ROWS, 7'd0);
    write_reg(abmw_pkg::REG_IDX_COLS, 7'd2);
    send_word(abmw_pkg::REQ_START, abmw_pkg::DIR_UP);
    send_word(abmw_pkg::REQ_STEP, abmw_pkg::DIR_RIGHT);
    send_word(abmw_pkg::REQ_STEP, abmw_pkg::DIR_DOWN);
  endtask

  // 2x2 grid: off-grid moves, carves, finish, ignored step after finish
  task automatic test_small_grid();
    settle_idle();
    write_reg(abmw_pkg::REG_IDX_ROWS, 7'd3);
    write_reg(abmw_pkg::REG_IDX_COLS, 7'd3);
    send_word(abmw_pkg::REQ_START, abmw_pkg::DIR_DOWN);
    send_word(abmw_pkg::REQ_STEP, abmw_pkg::DIR_UP);
    send_word(abmw_pkg::REQ_STEP, abmw_pkg::DIR_LEFT);
    send_word(abmw_pkg::REQ_STEP, abmw_pkg::DIR_RIGHT);
    send_word(abmw_pkg::REQ_STEP, abmw_pkg::DIR_RIGHT);
    send_word(abmw_pkg::REQ_STEP, abmw_pkg::DIR_DOWN);
    send_word(abmw_pkg::REQ_STEP, abmw_pkg::DIR_DOWN);
    send_word(abmw_pkg::REQ_STEP, abmw_pkg::DIR_LEFT);
    send_word(abmw_pkg::REQ_STEP, abmw_pkg::DIR_UP);
  endtask

  // oversized registers clamp, rewrite during a walk waits for the next start
  task automatic test_register_extremes();
    settle_idle();
    write_reg(abmw_pkg::REG_IDX_ROWS, 7'd127);
    write_reg(abmw_pkg::REG_IDX_COLS, 7'd64);
    send_word(abmw_pkg::REQ_START, abmw_pkg::DIR_LEFT);
    send_word(abmw_pkg::REQ_STEP, abmw_pkg::DIR_UP);
    send_word(abmw_pkg::REQ_STEP, abmw_pkg::DIR_LEFT);
    send_word(abmw_pkg::REQ_STEP, abmw_pkg::DIR_DOWN);
    send_word(abmw_pkg::REQ_STEP, abmw_pkg::DIR_RIGHT);
    settle_idle();
    write_reg(abmw_pkg::REG_IDX_ROWS, 7'd65);
    write_reg(abmw_pkg::REG_IDX_COLS, 7'd1);
    send_word(abmw_pkg::REQ_STEP, abmw_pkg::DIR_RIGHT);
    send_word(abmw_pkg::REQ_STEP, abmw_pkg::DIR_DOWN);
  endtask

  // long receiver hold while words keep coming, then a sender pause mid-walk
  task automatic test_output_backpressure();
    settle_idle();
    write_reg(abmw_pkg::REG_IDX_ROWS, 7'd9);
    write_reg(abmw_pkg::REG_IDX_COLS, 7'd9);
    no_gaps = 1'b1;
    long_hold_req <= 1'b1;
    send_word(abmw_pkg::REQ_START, abmw_pkg::DIR_UP);
    repeat (59) send_word(abmw_pkg::REQ_STEP, 2'($urandom_range(0, 3)));
    stop_sending();
    wait_drained();
    no_gaps = 1'b0;
    repeat (30) send_word(abmw_pkg::REQ_STEP, 2'($urandom_range(0, 3)));
  endtask

  // many grid shapes, corridors biased so the walk reaches the far end
  task automatic test_random_walks();
    run_phase(7'd5,   7'd5,   55, abmw_pkg::DIR_UP,    0);
    run_phase(7'd1,   7'd64,  100, abmw_pkg::DIR_RIGHT, 75);
    run_phase(7'd64,  7'd1,   100, abmw_pkg::DIR_DOWN,  75);
    run_phase(7'd7,   7'd3,   55, abmw_pkg::DIR_UP,    0);
    run_phase(7'd0,   7'd9,   55, abmw_pkg::DIR_UP,    0);
    run_phase(7'd127, 7'd2,   55, abmw_pkg::DIR_DOWN,  20);
    run_phase(7'd4,   7'd8,   55, abmw_pkg::DIR_UP,    0);
    run_phase(7'd8,   7'd8,   55, abmw_pkg::DIR_UP,    0);
    run_phase(7'd12,  7'd10,  55, abmw_pkg::DIR_UP,    0);
    run_phase(7'd65,  7'd6,   55, abmw_pkg::DIR_UP,    0);
    run_phase(7'd2,   7'd127, 55, abmw_pkg::DIR_RIGHT, 20);
    run_phase(7'd64,  7'd64,  40, abmw_pkg::DIR_UP,    0);
    run_phase(7'd6,   7'd3,   55, abmw_pkg::DIR_UP,    0);
  endtask

  // receiver stall pattern, with one long hold on request
  initial begin : rx_pattern
    int mode;
    int run_len;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        out_ready <= 1'b0;
        long_hold_req <= 1'b0;
        for (int k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        run_len = $urandom_range(8, 60);
        for (int k = 0; k < run_len && !long_hold_req; k++) begin
          case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            2: out_ready <= (k % 4 != 3);
            default: out_ready <= 1'($urandom_range(0, 1));
          endcase
          @(posedge clk);
        end
      end
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // compare each accepted result word with the oldest prediction
  always @(posedge clk) begin : check_results
    abmw_pkg::abmw_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (walk_reports_q.size() == 0) begin
        $error("result word with no request outstanding");
        fail_count++;
      end else begin
        want = walk_reports_q.pop_front();
        check_field("moved",    int'(want.moved),    int'(out_data.moved));
        check_field("carved",   int'(want.carved),   int'(out_data.carved));
        check_field("wall_row", int'(want.wall_row), int'(out_data.wall_row));
        check_field("wall_col", int'(want.wall_col), int'(out_data.wall_col));
        check_field("pos_row",  int'(want.pos_row),  int'(out_data.pos_row));
        check_field("pos_col",  int'(want.pos_col),  int'(out_data.pos_col));
        check_field("finished", int'(want.finished), int'(out_data.finished));
      end
    end
  end

  // test sequence
  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_steps();
    test_single_cell();
    test_small_grid();
    test_register_extremes();
    test_output_backpressure();
    test_random_walks();
    settle_idle();
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
